>>> rtl/core/console_line_editor_buffer_macros.svh
// Assertion macros shared by the line editor RTL.
`ifndef CONSOLE_LINE_EDITOR_BUFFER_MACROS_SVH
`define CONSOLE_LINE_EDITOR_BUFFER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CLEB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a non-overlapping implication outside reset.
`define CLEB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/core/cleb_pkg.sv
`default_nettype none

package cleb_pkg;

  typedef logic [7:0] char_t;

  // Control keys
  localparam char_t KEY_NUL  = 8'h00;
  localparam char_t KEY_EOF  = 8'h04;
  localparam char_t KEY_BS   = 8'h08;
  localparam char_t KEY_LF   = 8'h0a;
  localparam char_t KEY_CR   = 8'h0d;
  localparam char_t KEY_DUMP = 8'h10;
  localparam char_t KEY_KILL = 8'h15;
  localparam char_t KEY_DEL  = 8'h7f;

  // Largest erase count that fits the result field
  localparam char_t ERASE_MAX = 8'hff;

  // Display action
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_CHAR  = 2'd1;
  localparam logic [1:0] ECHO_ERASE = 2'd2;

  // Read outcome
  localparam logic [1:0] RD_NONE  = 2'd0;
  localparam logic [1:0] RD_DATA  = 2'd1;
  localparam logic [1:0] RD_EOF   = 2'd2;
  localparam logic [1:0] RD_EMPTY = 2'd3;

  // Input item selector
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_READ = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/console_line_editor_buffer.sv
// Each result is registered at its item's transfer.
// Throughput: one item per cycle unless a held result stalls the input; the
// store's registered read port keeps the byte at the read index ready.
// Reset (synchronous, rst_n low): read, commit and edit indices and the
// result valid flag clear; in_tready is held low. The line store is not
// cleared; no clearing pass.
`default_nettype none

module console_line_editor_buffer
  import cleb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 128
) (
  input  wire         clk,
  input  wire         rst_n,

  // Input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] key_char, [8] first_of_request, [15:9] zero
  input  wire  [0:0]  in_tuser,   // [0] mode

  // Result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [7:0] echo_char, [15:8] erase_count,
                                  // [16] dump_request, [17] wake_reader,
                                  // [25:18] read_byte, [31:26] zero
  output logic [3:0]  out_tuser,  // [1:0] echo_kind, [3:2] read_status
  output logic        out_tlast   // line_end
);

`include "console_line_editor_buffer_macros.svh"

  // Indices run modulo twice the depth so full and empty differ.
  localparam int IDX_MOD = 2 * BUFFER_DEPTH;
  localparam int IW      = $clog2(IDX_MOD);
  localparam int IW1     = IW + 1;
  localparam int AW      = $clog2(BUFFER_DEPTH);

  typedef logic [IW-1:0] idx_t;
  typedef logic [AW-1:0] slot_t;

  function automatic idx_t idx_inc(idx_t a);
    idx_inc = (a == idx_t'(IDX_MOD - 1)) ? '0 : a + idx_t'(1);
  endfunction

  function automatic idx_t idx_dec(idx_t a);
    idx_dec = (a == '0) ? idx_t'(IDX_MOD - 1) : a - idx_t'(1);
  endfunction

  function automatic idx_t idx_diff(idx_t a, idx_t b);
    logic [IW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[IW]) begin
      d = d + IW1'(IDX_MOD);
    end
    idx_diff = d[IW-1:0];
  endfunction

  function automatic slot_t slot_of(idx_t a);
    idx_t s;
    s = (a >= idx_t'(BUFFER_DEPTH)) ? a - idx_t'(BUFFER_DEPTH) : a;
    slot_of = s[AW-1:0];
  endfunction

  // Unpacked input fields
  logic  in_mode;
  char_t in_key;
  logic  in_first;

  assign in_mode  = in_tuser[0];
  assign in_key   = in_tdata[7:0];
  assign in_first = in_tdata[8];

  // Indices
  idx_t rd_r, rd_nxt;
  idx_t cm_r, cm_nxt;
  idx_t ed_r, ed_nxt;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] echo_kind_r, echo_kind_nxt;
  char_t      echo_char_r, echo_char_nxt;
  char_t      erase_cnt_r, erase_cnt_nxt;
  logic       dump_r, dump_nxt;
  logic       wake_r, wake_nxt;
  logic [1:0] rd_stat_r, rd_stat_nxt;
  char_t      rd_byte_r, rd_byte_nxt;
  logic       line_end_r, line_end_nxt;

  // Store ports
  logic  wr_en;
  char_t wr_data;
  char_t head;     // byte at the read index, registered by the store

  logic  in_xfer;
  idx_t  fill;     // edit - read
  idx_t  line_len; // edit - commit
  idx_t  cfill;    // commit - read
  char_t key;

  // Result slot frees when empty or being taken this cycle; nothing in reset.
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  assign fill     = idx_diff(ed_r, rd_r);
  assign line_len = idx_diff(ed_r, cm_r);
  assign cfill    = idx_diff(cm_r, rd_r);

  always_comb begin
    rd_nxt        = rd_r;
    cm_nxt        = cm_r;
    ed_nxt        = ed_r;
    wr_en         = 1'b0;
    key           = (in_key == KEY_CR) ? KEY_LF : in_key;
    wr_data       = key;
    echo_kind_nxt = ECHO_NONE;
    echo_char_nxt = '0;
    erase_cnt_nxt = '0;
    dump_nxt      = 1'b0;
    wake_nxt      = 1'b0;
    rd_stat_nxt   = RD_NONE;
    rd_byte_nxt   = '0;
    line_end_nxt  = 1'b0;

    if (in_xfer) begin
      if (in_mode == MODE_KEY) begin
        if (in_key == KEY_DUMP) begin
          dump_nxt = 1'b1;
        end else if (in_key == KEY_KILL) begin
          // drop the whole uncommitted line
          if (line_len != '0) begin
            echo_kind_nxt = ECHO_ERASE;
            erase_cnt_nxt = (line_len > idx_t'(ERASE_MAX)) ? ERASE_MAX : 8'(line_len);
            ed_nxt        = cm_r;
          end
        end else if (in_key == KEY_BS || in_key == KEY_DEL) begin
          if (ed_r != cm_r) begin
            ed_nxt        = idx_dec(ed_r);
            echo_kind_nxt = ECHO_ERASE;
            erase_cnt_nxt = 8'd1;
          end
        end else if (in_key != KEY_NUL && fill < idx_t'(BUFFER_DEPTH)) begin
          wr_en         = 1'b1;
          ed_nxt        = idx_inc(ed_r);
          echo_kind_nxt = ECHO_CHAR;
          echo_char_nxt = key;
          // newline, EOF or the last free slot closes the line
          if (key == KEY_LF || key == KEY_EOF || fill == idx_t'(BUFFER_DEPTH - 1)) begin
            cm_nxt   = ed_nxt;
            wake_nxt = 1'b1;
          end
        end
      end else begin
        if (rd_r == cm_r) begin
          rd_stat_nxt = RD_EMPTY;
        end else if (head == KEY_EOF) begin
          // EOF stays put unless it opens the request
          if (in_first) begin
            rd_nxt = idx_inc(rd_r);
          end
          rd_stat_nxt = RD_EOF;
        end else begin
          rd_nxt       = idx_inc(rd_r);
          rd_stat_nxt  = RD_DATA;
          rd_byte_nxt  = head;
          line_end_nxt = (head == KEY_LF);
        end
      end
    end
  end

  assign out_valid_nxt = in_xfer || (out_valid_r && !out_tready);

  // Store reads the slot of the next read index, so head follows it.
  cleb_ring #(
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_of(ed_r)),
    .wr_data (wr_data),
    .rd_addr (slot_of(rd_nxt)),
    .rd_data (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r        <= '0;
      cm_r        <= '0;
      ed_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_r        <= rd_nxt;
      cm_r        <= cm_nxt;
      ed_r        <= ed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload loads only on an input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      echo_kind_r <= echo_kind_nxt;
      echo_char_r <= echo_char_nxt;
      erase_cnt_r <= erase_cnt_nxt;
      dump_r      <= dump_nxt;
      wake_r      <= wake_nxt;
      rd_stat_r   <= rd_stat_nxt;
      rd_byte_r   <= rd_byte_nxt;
      line_end_r  <= line_end_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, rd_byte_r, wake_r, dump_r, erase_cnt_r, echo_char_r};
  assign out_tuser  = {rd_stat_r, echo_kind_r};
  assign out_tlast  = line_end_r;

  // Ring never holds more than its depth.
  `CLEB_ASSERT(a_fill_bound, fill <= idx_t'(BUFFER_DEPTH),
    "ring fill exceeds depth")

  // Commit index lies between read and edit.
  `CLEB_ASSERT(a_commit_order, cfill <= fill,
    "commit index outside read..edit")

  // Keys never move the read index.
  `CLEB_ASSERT_NEXT(a_key_keeps_read, in_xfer && in_mode == MODE_KEY, $stable(rd_r),
    "key transfer moved read index")

  // Reads never touch the edit line.
  `CLEB_ASSERT_NEXT(a_read_keeps_edit, in_xfer && in_mode == MODE_READ,
    $stable(ed_r) && $stable(cm_r), "read transfer moved commit or edit index")

endmodule

`default_nettype wire

>>> rtl/core/cleb_ring.sv
`default_nettype none

// Ring store: one write port, one registered read port.
// A write to the address being read in the same cycle is forwarded.
module cleb_ring
  import cleb_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
  input  char_t                     wr_data,
  input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
  output char_t                     rd_data
);

  char_t mem [DEPTH];
  char_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cleb_pkg::*;

  localparam int RING_DEPTH  = 128;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 520;

  // One keyboard or reader item as the block sees it
  typedef struct {
    logic  mode;
    char_t key;
    logic  first_rd;
  } tty_item_t;

  // One result item, split into its fields
  typedef struct {
    logic [1:0] echo_kind;
    char_t      echo_char;
    char_t      erase_count;
    logic       dump_request;
    logic       wake_reader;
    logic [1:0] read_status;
    char_t      read_byte;
    logic       line_end;
  } tty_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  console_line_editor_buffer #(
    .BUFFER_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line editor predictor: private copy of the ring and its three indices.
  // Indices run modulo twice the ring depth, which is exactly 8-bit wrap here.
  // ---------------------------------------------------------------------------
  char_t      ring_copy [RING_DEPTH];
  logic [7:0] rd_ptr   = '0;
  logic [7:0] done_ptr = '0;   // end of the committed lines
  logic [7:0] typ_ptr  = '0;   // end of the line being edited

  tty_item_t   items_to_send [$];
  tty_result_t display_and_read_due [$];
  int          mismatches = 0;

  function automatic tty_result_t edit_or_read(tty_item_t it);
    tty_result_t r;
    char_t       c;
    logic [7:0]  span;
    r = '{default: '0};
    if (it.mode == MODE_KEY) begin
      c = it.key;
      if (c == KEY_DUMP) begin
        r.dump_request = 1'b1;
      end else if (c == KEY_KILL) begin
        span = typ_ptr - done_ptr;
        if (span != 0) begin
          r.echo_kind   = ECHO_ERASE;
          r.erase_count = span;   // never above depth-1, so no saturation here
          typ_ptr       = done_ptr;
        end
      end else if (c == KEY_BS || c == KEY_DEL) begin
        if (typ_ptr != done_ptr) begin
          typ_ptr       = typ_ptr - 8'd1;
          r.echo_kind   = ECHO_ERASE;
          r.erase_count = 8'd1;
        end
      end else if (c != KEY_NUL && 8'(typ_ptr - rd_ptr) < RING_DEPTH) begin
        if (c == KEY_CR) c = KEY_LF;
        ring_copy[typ_ptr[6:0]] = c;
        typ_ptr     = typ_ptr + 8'd1;
        r.echo_kind = ECHO_CHAR;
        r.echo_char = c;
        // newline, end of file or a full ring closes the line
        if (c == KEY_LF || c == KEY_EOF || 8'(typ_ptr - rd_ptr) == RING_DEPTH) begin
          done_ptr      = typ_ptr;
          r.wake_reader = 1'b1;
        end
      end
    end else begin
      if (rd_ptr == done_ptr) begin
        r.read_status = RD_EMPTY;
      end else begin
        c = ring_copy[rd_ptr[6:0]];
        if (c == KEY_EOF) begin
          // end of file is only consumed by the opening read of a request
          if (it.first_rd) rd_ptr = rd_ptr + 8'd1;
          r.read_status = RD_EOF;
        end else begin
          rd_ptr        = rd_ptr + 8'd1;
          r.read_status = RD_DATA;
          r.read_byte   = c;
          r.line_end    = (c == KEY_LF);
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_key(char_t c);
    tty_item_t it;
    it.mode     = MODE_KEY;
    it.key      = c;
    it.first_rd = 1'($urandom_range(0, 1));   // ignored for keys
    items_to_send.push_back(it);
  endtask

  task automatic push_read(logic opening);
    tty_item_t it;
    it.mode     = MODE_READ;
    it.key      = 8'($urandom_range(0, 255)); // ignored for reads
    it.first_rd = opening;
    items_to_send.push_back(it);
  endtask

  // A typed line with the odd edit key mixed in, then its terminator
  task automatic type_line(int len, char_t ending);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8)       push_key($urandom_range(0, 1) ? KEY_BS : KEY_DEL);
      else if (r < 10) push_key(KEY_KILL);
      else if (r < 12) push_key(KEY_DUMP);
      else if (r < 16) push_key(8'($urandom_range(0, 255)));
      else             push_key(8'($urandom_range(8'h20, 8'h7e)));
    end
    push_key(ending);
  endtask

  task automatic read_request(int n);
    for (int i = 0; i < n; i++)
      push_read(i == 0 || $urandom_range(0, 7) == 0);
  endtask

  task automatic build_stimulus();
    int   r;
    int   len;
    bit   flooded;
    char_t ending;
    flooded = 1'b0;

    // directed opening
    push_key(KEY_NUL);                       // zero key is ignored
    push_read(1'b1);                         // nothing committed yet
    push_key(KEY_DUMP);
    push_key(KEY_KILL);                      // nothing to erase
    push_key(KEY_BS);
    push_key(KEY_DEL);
    push_key(8'h61);
    push_key(8'hff);
    push_key(KEY_BS);                        // single erase
    push_key(8'h01);
    push_key(KEY_KILL);                      // erase whole line
    push_key(8'h78);
    push_key(KEY_CR);                        // stored as newline, commits
    push_key(KEY_EOF);                       // commits an end-of-file line
    push_read(1'b1);
    push_read(1'b0);                         // newline, ends the request
    push_read(1'b0);                         // end of file, left in place
    push_read(1'b1);                         // end of file, consumed
    push_read(1'b1);                         // empty again
    push_key(8'h80);
    push_key(KEY_LF);
    push_read(1'b1);
    push_read(1'b0);

    // random part: mostly well-formed lines and read requests
    while (items_to_send.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (!flooded && items_to_send.size() > 120) begin
        // overrun the ring so it commits when full and drops the rest
        flooded = 1'b1;
        repeat (136) push_key(8'($urandom_range(8'h20, 8'h7e)));
        read_request(130);
      end else if (r < 48) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 110) : $urandom_range(0, 12);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: ending = KEY_LF;
          4, 5:       ending = KEY_CR;
          6, 7:       ending = KEY_EOF;
          default:    ending = KEY_KILL;   // abandon the line, often a long erase
        endcase
        type_line(len, ending);
      end else if (r < 85) begin
        read_request($urandom_range(1, 20));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 1)) push_key(8'($urandom_range(0, 255)));
          else                      push_read(1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers separated by random gaps
  // ---------------------------------------------------------------------------
  tty_item_t on_bus;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready)
        display_and_read_due.push_back(edit_or_read(on_bus));
      if (!in_tvalid || in_tready) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
        if (gap_left > 0 || items_to_send.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          on_bus = items_to_send.pop_front();
          burst_left--;
          in_tvalid <= 1'b1;
          in_tdata  <= {7'b0, on_bus.first_rd, on_bus.key};
          in_tuser  <= on_bus.mode;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: phases of full rate, random stalls and slow drain,
  // plus one long hold-off that backs the block up into its input.
  // ---------------------------------------------------------------------------
  int rx_cycles   = 0;
  int rx_phase    = 0;
  int rx_style    = 0;
  int rx_hold     = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == 600) rx_hold = 300;
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else begin
        if (rx_phase == 0) begin
          rx_style = $urandom_range(0, 2);
          rx_phase = $urandom_range(8, 80);
        end
        rx_phase--;
        case (rx_style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  tty_result_t due;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (display_and_read_due.size() == 0) begin
        $error("result transfer with no item outstanding");
        mismatches++;
      end else begin
        due = display_and_read_due.pop_front();
        check_field("echo_kind",    8'(due.echo_kind),    8'(out_tuser[1:0]));
        check_field("echo_char",    due.echo_char,        out_tdata[7:0]);
        check_field("erase_count",  due.erase_count,      out_tdata[15:8]);
        check_field("dump_request", 8'(due.dump_request), 8'(out_tdata[16]));
        check_field("wake_reader",  8'(due.wake_reader),  8'(out_tdata[17]));
        check_field("read_status",  8'(due.read_status),  8'(out_tuser[3:2]));
        check_field("read_byte",    due.read_byte,        out_tdata[25:18]);
        check_field("line_end",     8'(due.line_end),     8'(out_tlast));
      end
    end
  end

  // Watchdog
  int wd_cycles = 0;

  always @(posedge clk) begin
    wd_cycles++;
    if (wd_cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset once, run the stimulus, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (items_to_send.size() > 0 || in_tvalid || display_and_read_due.size() > 0)
      @(posedge clk);
    // let any stray result show up before the report
    repeat (8) @(posedge clk);
    if (mismatches == 0 && display_and_read_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> console_line_editor_buffer.f
+incdir+rtl/core
rtl/core/cleb_pkg.sv
rtl/core/cleb_ring.sv
rtl/core/console_line_editor_buffer.sv
verif/tb_top.sv
